[sv/shsc_pkg.sv]
// shsc_pkg: types and constants for the spill hit stream counter
// no dependencies; compiled first, used by the channel interfaces and the top level
`default_nettype none

package shsc_pkg;

   localparam int NUM_CHANNELS    = 8;
   localparam int CHAN_IDX_WIDTH  = 3;
   localparam int FIELD_WIDTH     = 22;
   localparam int WORD_WIDTH      = 32;
   localparam int LANE_WIDTH      = 2;
   localparam int CHAN_SUM_WIDTH  = 6;

   localparam logic [WORD_WIDTH-1:0] NIBBLE_MASK   = 32'hF000_0000;
   localparam logic [WORD_WIDTH-1:0] HEADER_CODE   = 32'h7000_0000;
   localparam logic [WORD_WIDTH-1:0] TRAILER_CODE  = 32'hF000_0000;
   localparam logic [WORD_WIDTH-1:0] ROLLOVER_WORD = 32'h5C5C_5C5C;

   // parse phase of the current buffer, one-hot
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_BODY   = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_MISMATCH   = 2'd1,
      ST_NO_TRAILER = 2'd2
   } status_type;

   typedef logic [FIELD_WIDTH-1:0] field_type;

   typedef struct packed {
      status_type                     status;
      field_type                      rollover;
      field_type                      hits;
      field_type [NUM_CHANNELS-1:0]   chan;
   } result_type;

endpackage

`default_nettype wire

[sv/shsc_if.sv]
// shsc_req_if and shsc_rsp_if: valid/ready channels of the spill hit stream counter
// depends on shsc_pkg for field widths
`default_nettype none

interface shsc_req_if import shsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] data_word;
   logic                  last_word;

   modport source (output valid, output data_word, output last_word, input ready);
   modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface shsc_rsp_if import shsc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             spill_status;
   logic [FIELD_WIDTH-1:0] rollover_count;
   logic [FIELD_WIDTH-1:0] hit_count;
   logic [FIELD_WIDTH-1:0] chan0_hits;
   logic [FIELD_WIDTH-1:0] chan1_hits;
   logic [FIELD_WIDTH-1:0] chan2_hits;
   logic [FIELD_WIDTH-1:0] chan3_hits;
   logic [FIELD_WIDTH-1:0] chan4_hits;
   logic [FIELD_WIDTH-1:0] chan5_hits;
   logic [FIELD_WIDTH-1:0] chan6_hits;
   logic [FIELD_WIDTH-1:0] chan7_hits;

   modport source (
      output valid, output spill_status, output rollover_count, output hit_count,
      output chan0_hits, output chan1_hits, output chan2_hits, output chan3_hits,
      output chan4_hits, output chan5_hits, output chan6_hits, output chan7_hits,
      input ready
   );
   modport sink (
      input valid, input spill_status, input rollover_count, input hit_count,
      input chan0_hits, input chan1_hits, input chan2_hits, input chan3_hits,
      input chan4_hits, input chan5_hits, input chan6_hits, input chan7_hits,
      output ready
   );
endinterface

`default_nettype wire

[sv/spill_hit_stream_counter_unit.sv]
// spill_hit_stream_counter_unit: top level of the spill hit stream counter
// depends on shsc_pkg and the channel interfaces in shsc_if.sv
`default_nettype none

// The unit parses a spill buffer one 32-bit word per transaction on req_if and
// returns one summary transaction on rsp_if at the end of each buffer. The first
// word is a header (top nibble 7), the second is skipped, and every later word is
// a trailer (top nibble F, ends the buffer with status ok), a rollover marker
// 0x5c5c5c5c, or a hit. Hits are counted in total and per channel, where the
// channel is pixel (bits 28..26) plus four times column (bits 31..29) minus eight
// times the lane written on the csr port; hits outside channels 0..7 only count
// in the total. A header mismatch returns status 1 with zero counts, a buffer
// marked last without a trailer returns status 2. Words after a trailer or a
// mismatch are dropped up to the word marked last. All counters are
// COUNT_WIDTH bits, saturate, and are reported in their low 22 bits.
// Timing: a word is registered on acceptance and then classified and counted from
// the input register, and one word is taken every cycle unless the input stalls;
// the output register lets the next word in while a summary waits,
// and input stalls only when a second summary would land on an untaken one.
// The lane register is sampled by the counting stage, so write it while idle.
module spill_hit_stream_counter_unit
   import shsc_pkg::*;
#(
   parameter int COUNT_WIDTH = 22
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [LANE_WIDTH-1:0] csr_write_data,
   shsc_req_if.sink                   req_if,
   shsc_rsp_if.source                 rsp_if
);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type COUNT_MAX = '1;

   // saturating increment
   function automatic count_type bump(input count_type c);
      bump = (c == COUNT_MAX) ? c : c + count_type'(1);
   endfunction

   // counter to reported field, zero extended or truncated to 22 bits
   function automatic field_type to_field(input count_type c);
      logic [WORD_WIDTH-1:0] wide;
      wide     = WORD_WIDTH'(c);
      to_field = wide[FIELD_WIDTH-1:0];
   endfunction

   // csr
   logic [LANE_WIDTH-1:0] lane_select_ff;

   // input register stage
   logic                  s1_valid_ff;
   logic [WORD_WIDTH-1:0] s1_word_ff;
   logic                  s1_last_ff;

   // parse state and counters
   phase_type phase_ff,    phase_in;
   count_type rollover_ff, rollover_in;
   count_type hits_ff,     hits_in;
   count_type [NUM_CHANNELS-1:0] chan_ff, chan_in;

   // result register
   logic       out_valid_ff;
   result_type out_data_ff;

   logic       emit;
   status_type status;
   logic       s1_fire;
   logic       req_fire;
   logic       rsp_fire;

   // channel decode
   logic [CHAN_SUM_WIDTH-1:0] chan_sum;
   logic [CHAN_SUM_WIDTH-1:0] lane_offset;
   logic [CHAN_SUM_WIDTH-1:0] chan_diff;
   logic                      chan_ok;
   logic [CHAN_IDX_WIDTH-1:0] chan_idx;
   logic                      is_header;
   logic                      is_trailer;
   logic                      is_rollover;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_select_ff <= '0;
      end else if (csr_write_enable) begin
         lane_select_ff <= csr_write_data;
      end
   end

   // handshakes
   assign req_fire      = req_if.valid && req_if.ready;
   assign rsp_fire      = out_valid_ff && rsp_if.ready;
   // the counting stage moves unless it has a summary and an untaken one is held
   assign s1_fire       = s1_valid_ff && (!emit || !out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_word_ff <= req_if.data_word;
         s1_last_ff <= req_if.last_word;
      end
   end

   // word classification
   assign is_header   = (s1_word_ff & NIBBLE_MASK) == HEADER_CODE;
   assign is_trailer  = (s1_word_ff & NIBBLE_MASK) == TRAILER_CODE;
   assign is_rollover = s1_word_ff == ROLLOVER_WORD;

   // channel = pixel + 4*column - 8*lane, kept only when it lands in 0..7
   assign chan_sum    = CHAN_SUM_WIDTH'(s1_word_ff[28:26])
                      + CHAN_SUM_WIDTH'({s1_word_ff[31:29], 2'b00});
   assign lane_offset = CHAN_SUM_WIDTH'({lane_select_ff, 3'b000});
   assign chan_diff   = chan_sum - lane_offset;
   assign chan_ok     = (chan_sum >= lane_offset)
                      && (chan_diff[CHAN_SUM_WIDTH-1:CHAN_IDX_WIDTH] == '0);
   assign chan_idx    = chan_diff[CHAN_IDX_WIDTH-1:0];

   // parse step for the word in the input register
   always_comb begin
      phase_in    = phase_ff;
      rollover_in = rollover_ff;
      hits_in     = hits_ff;
      chan_in     = chan_ff;
      emit        = 1'b0;
      status      = ST_OK;
      unique case (phase_ff)
         PH_HEADER: begin
            // any word in the header phase starts from zero counts
            rollover_in = '0;
            hits_in     = '0;
            chan_in     = '0;
            if (!is_header) begin
               emit     = 1'b1;
               status   = ST_MISMATCH;
               phase_in = s1_last_ff ? PH_HEADER : PH_DONE;
            end else if (s1_last_ff) begin
               emit     = 1'b1;
               status   = ST_NO_TRAILER;
               phase_in = PH_HEADER;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (s1_last_ff) begin
               emit     = 1'b1;
               status   = ST_NO_TRAILER;
               phase_in = PH_HEADER;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (is_trailer) begin
               emit     = 1'b1;
               status   = ST_OK;
               phase_in = s1_last_ff ? PH_HEADER : PH_DONE;
            end else begin
               if (is_rollover) begin
                  rollover_in = bump(rollover_ff);
               end else begin
                  hits_in = bump(hits_ff);
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     if (chan_ok && (chan_idx == CHAN_IDX_WIDTH'(i))) begin
                        chan_in[i] = bump(chan_ff[i]);
                     end
                  end
               end
               if (s1_last_ff) begin
                  emit     = 1'b1;
                  status   = ST_NO_TRAILER;
                  phase_in = PH_HEADER;
               end
            end
         end
         PH_DONE: begin
            // drop words up to the end of the buffer
            if (s1_last_ff) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         rollover_ff <= '0;
         hits_ff     <= '0;
         chan_ff     <= '0;
      end else if (s1_fire) begin
         phase_ff    <= phase_in;
         rollover_ff <= rollover_in;
         hits_ff     <= hits_in;
         chan_ff     <= chan_in;
      end
   end

   // result register, holds a summary until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && emit) begin
         out_data_ff.status   <= status;
         out_data_ff.rollover <= to_field(rollover_in);
         out_data_ff.hits     <= to_field(hits_in);
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            out_data_ff.chan[i] <= to_field(chan_in[i]);
         end
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.spill_status   = out_data_ff.status;
   assign rsp_if.rollover_count = out_data_ff.rollover;
   assign rsp_if.hit_count      = out_data_ff.hits;
   assign rsp_if.chan0_hits     = out_data_ff.chan[0];
   assign rsp_if.chan1_hits     = out_data_ff.chan[1];
   assign rsp_if.chan2_hits     = out_data_ff.chan[2];
   assign rsp_if.chan3_hits     = out_data_ff.chan[3];
   assign rsp_if.chan4_hits     = out_data_ff.chan[4];
   assign rsp_if.chan5_hits     = out_data_ff.chan[5];
   assign rsp_if.chan6_hits     = out_data_ff.chan[6];
   assign rsp_if.chan7_hits     = out_data_ff.chan[7];

   // a new summary only comes from a word that was waiting in the input register
   a_summary_source : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("summary appeared without a word in the counting stage");

   // a mismatch summary carries cleared counts
   a_mismatch_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status == ST_MISMATCH)
         |-> (out_data_ff.rollover == '0 && out_data_ff.hits == '0))
      else $error("mismatch summary with nonzero counts");

   // hit total only drops when a header word is processed
   a_hits_monotonic : assert property (@(posedge clock) disable iff (reset)
      !(s1_fire && phase_ff == PH_HEADER) |=> hits_ff >= $past(hits_ff))
      else $error("hit total decreased outside a header word");

   // an untaken summary is never overwritten by the counting stage
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready) |-> !(s1_fire && emit))
      else $error("summary overwritten before it was taken");

endmodule

`default_nettype wire
